/* hdl/upq_pkg.sv */
package upq_pkg;

    localparam int DEPTH      = 64;
    localparam int TAG_BITS   = 32;
    localparam int PRIO_BITS  = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = TAG_BITS + PRIO_BITS;

    typedef logic [TAG_BITS-1:0]         t_tag;
    typedef logic signed [PRIO_BITS-1:0] t_prio;
    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic [CNT_BITS-1:0]         t_count;
    typedef logic [2:0]                  t_cmd;
    typedef logic [1:0]                  t_status;

    typedef struct packed {
        t_tag  tag;
        t_prio prio;
    } t_entry;

    localparam t_cmd CMD_ENQUEUE = 3'd0;
    localparam t_cmd CMD_DEQUEUE = 3'd1;
    localparam t_cmd CMD_PEEK    = 3'd2;
    localparam t_cmd CMD_CHANGE  = 3'd3;
    localparam t_cmd CMD_CLEAR   = 3'd4;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_EMPTY      = 2'd1;
    localparam t_status ST_FULL       = 2'd2;
    localparam t_status ST_LESS_URGENT = 2'd3;

    // 32-bit port tag to stored tag (keeps the low TAG_BITS bits)
    function automatic t_tag to_tag(input logic [31:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[TAG_BITS-1:0];
    endfunction

    // stored tag to 32-bit port tag (low 32 bits)
    function automatic logic [31:0] from_tag(input t_tag t);
        logic [63:0] w;
        w = 64'(t);
        return w[31:0];
    endfunction

    function automatic logic [6:0] count_out(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return w[6:0];
    endfunction

endpackage

/* hdl/upq_ram.sv */
module upq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/unsorted_array_priority_queue.sv */
// channel  direction  handshake           payload
// command  in         i_valid / o_stall   i_command, i_value_tag, i_priority_in
// result   out        o_valid / i_stall   o_out_tag, o_out_priority, o_status, o_entry_count
//
// One command at a time; the entry RAM has one read and one write port.
// Enqueue, clear and commands on an empty store go straight to the result. Peek and
// change priority scan the entries (one RAM read per entry); dequeue scans, then
// shifts each entry behind the removed one down by one place.
// Synchronous active-low reset clears the count and control; the RAM is not cleared.
// A stalled result holds; the next command may be taken meanwhile but finishes only
// once the output register is free.
module unsorted_array_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_value_tag,
    input  logic signed [31:0] i_priority_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_tag,
    output logic signed [31:0] o_out_priority,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count
);
    import upq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    t_count  r_count, n_count;
    t_cmd    r_cmd, n_cmd;
    t_tag    r_tag, n_tag;
    t_prio   r_prio, n_prio;
    t_addr   r_idx, n_idx;
    t_entry  r_best, n_best;
    t_addr   r_best_idx, n_best_idx;
    logic [31:0] r_res_tag, n_res_tag;
    t_prio   r_res_prio, n_res_prio;
    t_status r_res_status, n_res_status;
    logic    r_o_valid, n_o_valid;
    logic [31:0] r_o_tag, n_o_tag;
    t_prio   r_o_prio, n_o_prio;
    t_status r_o_status, n_o_status;
    logic [6:0] r_o_count, n_o_count;

    logic    ram_we;
    t_addr   ram_waddr, ram_raddr;
    t_entry  ram_wdata, ram_rdata;

    upq_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    t_count idx_c;
    logic   scan_last, shift_last, better, take;
    t_entry cur;
    t_addr  cur_idx;

    always_comb begin
        idx_c      = CNT_BITS'(r_idx);
        scan_last  = (idx_c + t_count'(1)) == r_count;
        shift_last = (idx_c + t_count'(2)) == r_count;
        better     = (ram_rdata.prio < r_best.prio) ||
                     ((ram_rdata.prio == r_best.prio) && (ram_rdata.tag < r_best.tag));
        take       = (r_idx == '0) || better;
        cur        = take ? ram_rdata : r_best;
        cur_idx    = take ? r_idx : r_best_idx;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_tag        = r_tag;
        n_prio       = r_prio;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_res_tag    = r_res_tag;
        n_res_prio   = r_res_prio;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid;
        n_o_tag      = r_o_tag;
        n_o_prio     = r_o_prio;
        n_o_status   = r_o_status;
        n_o_count    = r_o_count;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_idx + t_addr'(1);

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd        = i_command;
                    n_tag        = to_tag(i_value_tag);
                    n_prio       = i_priority_in;
                    n_res_tag    = '0;
                    n_res_prio   = '0;
                    n_res_status = ST_OK;
                    n_idx        = '0;
                    ram_raddr    = '0;
                    n_state      = S_DONE;
                    case (i_command)
                        CMD_ENQUEUE: begin
                            if (r_count == t_count'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_BITS-1:0];
                                ram_wdata = '{tag: to_tag(i_value_tag), prio: i_priority_in};
                                n_count   = r_count + t_count'(1);
                            end
                        end
                        CMD_DEQUEUE, CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_CHANGE: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_cmd == CMD_CHANGE) begin
                    if (ram_rdata.tag == r_tag) begin
                        if (r_prio <= ram_rdata.prio) begin
                            ram_we    = 1'b1;
                            ram_wdata = '{tag: ram_rdata.tag, prio: r_prio};
                        end else begin
                            n_res_status = ST_LESS_URGENT;
                        end
                        n_state = S_DONE;
                    end else if (scan_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + t_addr'(1);
                    end
                end else begin
                    n_best     = cur;
                    n_best_idx = cur_idx;
                    if (scan_last) begin
                        n_res_tag  = from_tag(cur.tag);
                        n_res_prio = cur.prio;
                        n_state    = S_DONE;
                        if (r_cmd == CMD_DEQUEUE) begin
                            if ((CNT_BITS'(cur_idx) + t_count'(1)) == r_count) begin
                                n_count = r_count - t_count'(1);
                            end else begin
                                // close the gap: read idx+1, write idx
                                ram_raddr = cur_idx + t_addr'(1);
                                n_idx     = cur_idx;
                                n_state   = S_SHIFT;
                            end
                        end
                    end else begin
                        n_idx = r_idx + t_addr'(1);
                    end
                end
            end

            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (shift_last) begin
                    n_count = r_count - t_count'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx     = r_idx + t_addr'(1);
                    ram_raddr = r_idx + t_addr'(2);
                end
            end

            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_tag    = r_res_tag;
                    n_o_prio   = r_res_prio;
                    n_o_status = r_res_status;
                    n_o_count  = count_out(r_count);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_cmd        <= n_cmd;
        r_tag        <= n_tag;
        r_prio       <= n_prio;
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_res_tag    <= n_res_tag;
        r_res_prio   <= n_res_prio;
        r_res_status <= n_res_status;
        r_o_tag      <= n_o_tag;
        r_o_prio     <= n_o_prio;
        r_o_status   <= n_o_status;
        r_o_count    <= n_o_count;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_out_tag      = r_o_tag;
    assign o_out_priority = r_o_prio;
    assign o_status       = r_o_status;
    assign o_entry_count  = r_o_count;

endmodule

/* sim/upq_reply_checker.sv */
module upq_reply_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_stall,
    input  logic [2:0]         i_command,
    input  logic [31:0]        i_value_tag,
    input  logic signed [31:0] i_priority_in,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [31:0]        i_out_tag,
    input  logic signed [31:0] i_out_priority,
    input  logic [1:0]         i_status,
    input  logic [6:0]         i_entry_count,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import upq_pkg::*;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] prio;
        t_status     status;
        logic [6:0]  count;
    } t_reply;

    // shadow copy of the queue contents, insertion order
    t_tag  shadow_tag [DEPTH];
    t_prio shadow_prio[DEPTH];
    int    shadow_count;

    t_reply replies_due[$];
    t_reply want;
    t_reply got;

    function automatic t_reply predict_reply(t_cmd cmd, logic [31:0] tag_in, t_prio prio_in);
        t_reply r;
        t_tag   tag;
        int     best;
        int     idx;
        r   = '0;
        tag = tag_in;
        case (cmd)
            CMD_ENQUEUE: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_tag[shadow_count]  = tag;
                    shadow_prio[shadow_count] = prio_in;
                    shadow_count++;
                end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (idx = 1; idx < shadow_count; idx++) begin
                        if (shadow_prio[idx] < shadow_prio[best] ||
                            (shadow_prio[idx] == shadow_prio[best] &&
                             shadow_tag[idx] < shadow_tag[best]))
                            best = idx;
                    end
                    r.tag  = shadow_tag[best];
                    r.prio = shadow_prio[best];
                    if (cmd == CMD_DEQUEUE) begin
                        for (idx = best; idx < shadow_count - 1; idx++) begin
                            shadow_tag[idx]  = shadow_tag[idx + 1];
                            shadow_prio[idx] = shadow_prio[idx + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            CMD_CHANGE: begin
                // only the first entry with this tag is touched
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_tag[idx] == tag) begin
                        if (prio_in <= shadow_prio[idx])
                            shadow_prio[idx] = prio_in;
                        else
                            r.status = ST_LESS_URGENT;
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                shadow_count = 0;
            end
            default: ;
        endcase
        r.count = 7'(shadow_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                got = {i_out_tag, i_out_priority, i_status, i_entry_count};
                if (replies_due.size() == 0) begin
                    $error("reply transfer with nothing outstanding: tag %0h prio %0d status %0d",
                           i_out_tag, i_out_priority, i_status);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.tag !== want.tag) begin
                        $error("out_tag mismatch: expected %0h, got %0h", want.tag, got.tag);
                        o_fail_count++;
                    end
                    if (got.prio !== want.prio) begin
                        $error("out_priority mismatch: expected %0d, got %0d",
                               $signed(want.prio), $signed(got.prio));
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.count, got.count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall)
                replies_due.push_back(predict_reply(i_command, i_value_tag, i_priority_in));
            o_pending = replies_due.size();
        end
    end

endmodule

/* sim/tb_unsorted_array_priority_queue.sv */
module tb_unsorted_array_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import upq_pkg::*;

    localparam int N_RANDOM     = 1400;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT        = 1500000;

    localparam t_prio PRIO_MIN = 32'sh8000_0000;
    localparam t_prio PRIO_MAX = 32'sh7fff_ffff;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_command;
    logic [31:0]        i_value_tag;
    logic signed [31:0] i_priority_in;
    logic               o_valid;
    logic               i_stall;
    logic [31:0]        o_out_tag;
    logic signed [31:0] o_out_priority;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;

    int          fail_count;
    int          pending;
    int          n_items;
    int unsigned cyc;
    bit          hold_req;
    bit          no_gaps;

    unsorted_array_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value_tag    (i_value_tag),
        .i_priority_in  (i_priority_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_tag      (o_out_tag),
        .o_out_priority (o_out_priority),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    upq_reply_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_stall    (o_stall),
        .i_command      (i_command),
        .i_value_tag    (i_value_tag),
        .i_priority_in  (i_priority_in),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_out_tag      (o_out_tag),
        .i_out_priority (o_out_priority),
        .i_status       (o_status),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cyc = 0;
    always @(posedge i_clk) cyc <= cyc + 1;

    initial begin
        wait (cyc >= LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: segments of different stall density, plus a long hold-off on each request
    initial begin
        int unsigned burst;
        int unsigned pct;
        int unsigned seg;
        burst   = 0;
        pct     = 0;
        seg     = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg == 0) begin
                seg = $urandom_range(100, 400);
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 15;
                    default: pct = 40;
                endcase
            end
            seg--;
            if (hold_req) begin
                hold_req = 1'b0;
                burst    = LONG_HOLD;
            end
            if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if ($urandom_range(0, 99) < pct) begin
                i_stall <= 1'b1;
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // small tag pool so change-priority finds matches and ties on priority break by tag
    function automatic logic [31:0] rand_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 15);
        if (r < 70) begin
            case ($urandom_range(0, 2))
                0:       return 32'h0000_0000;
                1:       return 32'hffff_ffff;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom();
    endfunction

    function automatic t_prio rand_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return t_prio'($urandom_range(0, 8)) - 4;
        if (r < 55) begin
            case ($urandom_range(0, 5))
                0:       return PRIO_MIN;
                1:       return PRIO_MAX;
                2:       return PRIO_MIN + 1;
                3:       return PRIO_MAX - 1;
                4:       return 0;
                default: return -1;
            endcase
        end
        return t_prio'($urandom());
    endfunction

    // leaves i_valid high after the transfer; the caller lowers it only for a gap
    task automatic send_cmd(input t_cmd cmd, input logic [31:0] tag, input t_prio prio);
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_value_tag   <= tag;
        i_priority_in <= prio;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        n_items++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_gapped(input t_cmd cmd, input logic [31:0] tag, input t_prio prio);
        send_cmd(cmd, tag, prio);
        idle_sender(pick_gap());
    endtask

    task automatic wait_drained();
        idle_sender(1);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    task automatic mixed_burst(input int len, input int enq_pct);
        int r;
        repeat (len) begin
            if ($urandom_range(0, 99) < enq_pct) begin
                send_gapped(CMD_ENQUEUE, rand_tag(), rand_prio());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_gapped(CMD_DEQUEUE, $urandom(), t_prio'($urandom()));
                else if (r < 55)
                    send_gapped(CMD_PEEK, $urandom(), t_prio'($urandom()));
                else if (r < 92)
                    send_gapped(CMD_CHANGE, rand_tag(), rand_prio());
                else if (r < 94)
                    send_gapped(CMD_CLEAR, $urandom(), t_prio'($urandom()));
                else
                    send_gapped(t_cmd'($urandom_range(5, 7)), $urandom(), t_prio'($urandom()));
            end
        end
    endtask

    initial begin
        int sel;
        n_items       = 0;
        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_ENQUEUE;
        i_value_tag   <= '0;
        i_priority_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, ties, change outcomes, unused codes
        send_gapped(CMD_DEQUEUE, 32'h0, 0);
        send_gapped(CMD_PEEK,    32'hffff_ffff, PRIO_MIN);
        send_gapped(CMD_CHANGE,  32'h7, 0);
        send_gapped(CMD_ENQUEUE, 32'h0, PRIO_MAX);
        send_gapped(CMD_ENQUEUE, 32'hffff_ffff, PRIO_MIN);
        send_gapped(CMD_ENQUEUE, 32'h5, PRIO_MIN);
        send_gapped(CMD_ENQUEUE, 32'h5, 3);
        send_gapped(CMD_PEEK,    32'h0, 0);
        send_gapped(CMD_CHANGE,  32'h5, PRIO_MIN);
        send_gapped(CMD_CHANGE,  32'h0, 100);
        send_gapped(CMD_CHANGE,  32'h0, PRIO_MAX);
        send_gapped(CMD_CHANGE,  32'hffff_ffff, -1);
        send_gapped(CMD_CHANGE,  32'h1234, PRIO_MIN);
        send_gapped(t_cmd'(5),   32'hffff_ffff, PRIO_MAX);
        send_gapped(t_cmd'(6),   32'h0, PRIO_MIN);
        send_gapped(t_cmd'(7),   32'h5, -1);
        send_gapped(CMD_DEQUEUE, 32'h0, 0);
        send_gapped(CMD_DEQUEUE, 32'h0, 0);
        send_gapped(CMD_PEEK,    32'h0, 0);
        send_gapped(CMD_CLEAR,   32'h0, 0);
        send_gapped(CMD_PEEK,    32'h0, 0);
        send_gapped(CMD_DEQUEUE, 32'h0, 0);
        send_gapped(CMD_ENQUEUE, 32'h1, 0);
        send_gapped(CMD_CLEAR,   32'hffff_ffff, PRIO_MAX);
        wait_drained();

        // back-pressure: result side holds off at the start of a burst that fills the store past full
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        mixed_burst(80, 95);
        no_gaps  = 1'b0;
        wait_drained();
        mixed_burst(80, 5);

        while (n_items < N_RANDOM) begin
            sel     = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (sel < 12)
                mixed_burst(70, 90);
            else if (sel < 24)
                mixed_burst(70, 5);
            else
                mixed_burst($urandom_range(10, 30), 50);
            if ($urandom_range(0, 39) == 0)
                hold_req = 1'b1;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
